@@ rtl/sclm_pkg.sv @@
package sclm_pkg;

   localparam int VISIBLE_COLUMNS = 32;
   localparam int STORE_COLUMNS   = 256;

   localparam int STORE_AW    = $clog2(STORE_COLUMNS);
   localparam int VIS_W       = $clog2(VISIBLE_COLUMNS);
   localparam int SCROLL_W    = 16;
   localparam int DIV_CNT_W   = $clog2(SCROLL_W);
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int GLYPH_ROWS_W = 64;
   localparam int WRAP_MARGIN = 8;
   localparam int BLANK_WIDTH = 4;
   localparam int GLYPH_WIDTH = 8;

   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_SHOW   = 2'd2;
   localparam logic [1:0] FUNC_TICK   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MONOSPACE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_ENABLE = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0][7:0] cols;
      logic [2:0]      first;
      logic [3:0]      width;
   } glyph_type;

   typedef struct packed {
      logic [2:0] display_index;
      logic [2:0] column_index;
      logic [7:0] column_bits;
      logic       last;
   } column_type;

endpackage

@@ rtl/sclm_ifs.sv @@
interface sclm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             func;
   logic [sclm_pkg::GLYPH_ROWS_W-1:0]      glyph_rows;

   modport source (output valid, output func, output glyph_rows, input ready);
   modport sink (input valid, input func, input glyph_rows, output ready);
endinterface

interface sclm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] display_index;
   logic [2:0] column_index;
   logic [7:0] column_bits;
   logic       last;

   modport source (output valid, output display_index, output column_index,
                   output column_bits, output last, input ready);
   modport sink (input valid, input display_index, input column_index,
                 input column_bits, input last, output ready);
endinterface

interface sclm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sclm_pkg::CSR_INDEX_W-1:0]   index;
   logic [sclm_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sclm_ram.sv @@
module sclm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/sclm_glyph.sv @@
module sclm_glyph (
   input  logic [sclm_pkg::GLYPH_ROWS_W-1:0] rows,
   input  logic                              monospace,
   output sclm_pkg::glyph_type               glyph
);

   logic [7:0][7:0] cols;
   logic [7:0]      nz;
   logic [3:0]      left;
   logic [2:0]      last_nz;
   logic [2:0]      right_raw;
   logic [3:0]      left_trim;
   logic [2:0]      right_trim;

   // transpose rows into columns, bit 7 of a row is column 0
   always_comb begin
      for (int c = 0; c < 8; c++) begin
         for (int r = 0; r < 8; r++) begin
            cols[c][r] = rows[8*r + 7 - c];
         end
         nz[c] = |cols[c];
      end
   end

   always_comb begin
      left = 4'd8;
      for (int c = 7; c >= 0; c--) begin
         if (nz[c]) begin
            left = 4'(c);
         end
      end
      // right scan never looks at column 0
      last_nz = 3'd0;
      for (int c = 1; c < 8; c++) begin
         if (nz[c]) begin
            last_nz = 3'(c);
         end
      end
      right_raw  = 3'd7 - last_nz;
      left_trim  = (left != 4'd0) ? left - 4'd1 : 4'd0;
      right_trim = (right_raw != 3'd0) ? right_raw - 3'd1 : 3'd0;

      glyph.cols = cols;
      if (monospace) begin
         glyph.first = 3'd0;
         glyph.width = 4'(sclm_pkg::GLYPH_WIDTH);
      end else if (left_trim >= 4'd7) begin
         // blank glyph becomes a space
         glyph.first = 3'd0;
         glyph.width = 4'(sclm_pkg::BLANK_WIDTH);
      end else begin
         glyph.first = left_trim[2:0];
         glyph.width = 4'(sclm_pkg::GLYPH_WIDTH) - left_trim - {1'b0, right_trim};
      end
   end

endmodule

@@ rtl/scrolling_led_matrix_text_top.sv @@
// channel  dir  handshake      payload
// req_if   in   valid/ready    func[1:0], glyph_rows[63:0]
// rsp_if   out  valid/ready    display_index[2:0], column_index[2:0], column_bits[7:0], last
// csr_if   in   valid/ready    index[7:0], data[7:0] (bit 0 used)
//
// append writes glyph width columns to the store (2 to 8 column writes)
// show reads VISIBLE_COLUMNS columns, one store read per cycle while the buffer has room
// tick adds a division for the remainder of the scroll position by the wrap length
// reset clears control only: store entries at or past the write pointer read as zero
// reads pause while rsp_if stalls and held plus in-flight columns fill the two-entry buffer
module scrolling_led_matrix_text_top (
   input logic          clock,
   input logic          reset,
   sclm_req_if.sink     req_if,
   sclm_rsp_if.source   rsp_if,
   sclm_csr_if.sink     csr_if
);

   localparam int AW = sclm_pkg::STORE_AW;
   localparam int VW = sclm_pkg::VIS_W;
   localparam int SW = sclm_pkg::SCROLL_W;
   localparam int CW = sclm_pkg::DIV_CNT_W;

   sclm_pkg::state_type  state_ff, state_in;
   logic                 monospace_ff, monospace_in;
   logic                 scroll_enable_ff, scroll_enable_in;
   logic [AW-1:0]        wp_ff, wp_in;
   logic [SW-1:0]        sp_ff, sp_in;
   logic                 full_ff, full_in;
   sclm_pkg::glyph_type  glyph_ff, glyph_in;
   logic [2:0]           app_cnt_ff, app_cnt_in;
   logic [AW:0]          wrap_ff, wrap_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [VW-1:0]        col_ff, col_in;
   logic [SW-1:0]        div_num_ff, div_num_in;
   logic [AW-1:0]        div_rem_ff, div_rem_in;
   logic [CW-1:0]        div_cnt_ff, div_cnt_in;
   logic                 inflight_ff, inflight_in;
   sclm_pkg::column_type meta_ff, meta_in;
   logic                 zero_ff, zero_in;
   sclm_pkg::column_type fifo0_ff, fifo0_in;
   sclm_pkg::column_type fifo1_ff, fifo1_in;
   logic [1:0]           count_ff, count_in;

   sclm_pkg::glyph_type  glyph;
   logic                 req_fire;
   logic                 csr_fire;
   logic                 pop;
   logic [AW:0]          wp_end;
   logic                 fits;
   logic [AW:0]          wp_plus8;
   logic [AW:0]          wrap_calc;
   logic                 emit_issue;
   logic                 col_last;
   logic [AW:0]          ptr_inc;
   logic [AW:0]          div_t;
   logic                 div_ge;
   logic [AW-1:0]        div_rem_next;
   logic                 div_done;
   logic                 app_done;
   logic [1:0]           cnt_after;
   sclm_pkg::column_type push_item;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [7:0]           ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [7:0]           ram_rdata;

   sclm_glyph u_glyph (
      .rows      (req_if.glyph_rows),
      .monospace (monospace_ff),
      .glyph     (glyph)
   );

   sclm_ram #(
      .WIDTH (8),
      .DEPTH (sclm_pkg::STORE_COLUMNS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_fire = req_if.valid & req_if.ready;
   assign csr_fire = csr_if.valid & csr_if.ready;
   assign pop      = rsp_if.valid & rsp_if.ready;

   // append fit check and wrap length
   assign wp_end   = {1'b0, wp_ff} + (AW+1)'(glyph.width);
   assign fits     = wp_end < (AW+1)'(sclm_pkg::STORE_COLUMNS);
   assign wp_plus8 = {1'b0, wp_ff} + (AW+1)'(sclm_pkg::WRAP_MARGIN);

   always_comb begin
      if ({1'b0, wp_ff} < (AW+1)'(sclm_pkg::VISIBLE_COLUMNS)) begin
         wrap_calc = (AW+1)'(sclm_pkg::VISIBLE_COLUMNS + sclm_pkg::WRAP_MARGIN);
      end else if (wp_plus8 < (AW+1)'(sclm_pkg::STORE_COLUMNS)) begin
         wrap_calc = wp_plus8;
      end else begin
         wrap_calc = (AW+1)'(sclm_pkg::STORE_COLUMNS);
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign div_t        = {div_rem_ff, div_num_ff[SW-1]};
   assign div_ge       = div_t >= wrap_ff;
   assign div_rem_next = div_ge ? AW'(div_t - wrap_ff) : AW'(div_t);
   assign div_done     = div_cnt_ff == CW'(SW - 1);

   assign app_done = {1'b0, app_cnt_ff} == (glyph_ff.width - 4'd1);

   // read only with room for the returning column
   assign emit_issue = (state_ff == sclm_pkg::ST_EMIT) &&
                       (({1'b0, count_ff} + {2'b0, inflight_ff}) <= (3'd1 + {2'b0, pop}));
   assign col_last   = col_ff == VW'(sclm_pkg::VISIBLE_COLUMNS - 1);
   assign ptr_inc    = {1'b0, ptr_ff} + (AW+1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sclm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_if.func)
                  sclm_pkg::FUNC_START: begin
                     state_in = sclm_pkg::ST_IDLE;
                  end
                  sclm_pkg::FUNC_APPEND: begin
                     if (!full_ff && fits) begin
                        state_in = sclm_pkg::ST_APPEND;
                     end
                  end
                  sclm_pkg::FUNC_SHOW: begin
                     state_in = sclm_pkg::ST_EMIT;
                  end
                  sclm_pkg::FUNC_TICK: begin
                     if (scroll_enable_ff) begin
                        state_in = sclm_pkg::ST_DIVIDE;
                     end
                  end
                  default: begin
                     state_in = sclm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         sclm_pkg::ST_APPEND: begin
            if (app_done) begin
               state_in = sclm_pkg::ST_IDLE;
            end
         end
         sclm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = sclm_pkg::ST_EMIT;
            end
         end
         sclm_pkg::ST_EMIT: begin
            if (emit_issue && col_last) begin
               state_in = sclm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sclm_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = state_ff == sclm_pkg::ST_IDLE;
      ram_we       = state_ff == sclm_pkg::ST_APPEND;
      ram_waddr    = wp_ff;
      ram_wdata    = glyph_ff.cols[3'(glyph_ff.first + app_cnt_ff)];
      ram_re       = emit_issue;
      ram_raddr    = ptr_ff;
   end

   // config writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      monospace_in     = monospace_ff;
      scroll_enable_in = scroll_enable_ff;
      if (csr_fire) begin
         unique case (csr_if.index)
            sclm_pkg::CSR_MONOSPACE: begin
               monospace_in = csr_if.data[0];
            end
            sclm_pkg::CSR_SCROLL_ENABLE: begin
               scroll_enable_in = csr_if.data[0];
            end
            default: begin
               monospace_in = monospace_ff;
            end
         endcase
      end
   end

   // datapath
   always_comb begin
      wp_in      = wp_ff;
      sp_in      = sp_ff;
      full_in    = full_ff;
      glyph_in   = glyph_ff;
      app_cnt_in = app_cnt_ff;
      wrap_in    = wrap_ff;
      ptr_in     = ptr_ff;
      col_in     = col_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      meta_in    = meta_ff;
      zero_in    = zero_ff;

      case (state_ff)
         sclm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_if.func)
                  sclm_pkg::FUNC_START: begin
                     wp_in   = '0;
                     sp_in   = '0;
                     full_in = 1'b0;
                  end
                  sclm_pkg::FUNC_APPEND: begin
                     if (full_ff || !fits) begin
                        full_in = 1'b1;
                     end else begin
                        glyph_in   = glyph;
                        app_cnt_in = '0;
                     end
                  end
                  sclm_pkg::FUNC_SHOW: begin
                     sp_in   = '0;
                     ptr_in  = '0;
                     col_in  = '0;
                     wrap_in = wrap_calc;
                  end
                  default: begin
                     if (scroll_enable_ff) begin
                        div_num_in = sp_ff;
                        div_rem_in = '0;
                        div_cnt_in = '0;
                        wrap_in    = wrap_calc;
                        col_in     = '0;
                        sp_in      = sp_ff + SW'(1);
                     end
                  end
               endcase
            end
         end
         sclm_pkg::ST_APPEND: begin
            wp_in      = wp_ff + AW'(1);
            app_cnt_in = app_cnt_ff + 3'd1;
         end
         sclm_pkg::ST_DIVIDE: begin
            div_num_in = {div_num_ff[SW-2:0], 1'b0};
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff + CW'(1);
            ptr_in     = div_rem_next;
         end
         default: begin
            if (emit_issue) begin
               ptr_in                = (ptr_inc == wrap_ff) ? '0 : ptr_inc[AW-1:0];
               col_in                = col_ff + VW'(1);
               meta_in.display_index = 3'(col_ff >> 3);
               meta_in.column_index  = ~col_ff[2:0];
               meta_in.column_bits   = '0;
               meta_in.last          = col_last;
               // at or past the write pointer the store reads as cleared
               zero_in               = ptr_ff >= wp_ff;
            end
         end
      endcase
   end

   // result buffer
   always_comb begin
      inflight_in = emit_issue;
      push_item   = meta_ff;
      push_item.column_bits = zero_ff ? 8'd0 : ram_rdata;
      cnt_after   = count_ff - {1'b0, pop};
      fifo0_in    = pop ? fifo1_ff : fifo0_ff;
      fifo1_in    = fifo1_ff;
      if (inflight_ff) begin
         if (cnt_after == 2'd0) begin
            fifo0_in = push_item;
         end else begin
            fifo1_in = push_item;
         end
      end
      count_in = cnt_after + {1'b0, inflight_ff};
   end

   assign rsp_if.valid         = count_ff != 2'd0;
   assign rsp_if.display_index = fifo0_ff.display_index;
   assign rsp_if.column_index  = fifo0_ff.column_index;
   assign rsp_if.column_bits   = fifo0_ff.column_bits;
   assign rsp_if.last          = fifo0_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sclm_pkg::ST_IDLE;
         monospace_ff     <= 1'b0;
         scroll_enable_ff <= 1'b1;
         wp_ff            <= '0;
         sp_ff            <= '0;
         full_ff          <= 1'b0;
         inflight_ff      <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         state_ff         <= state_in;
         monospace_ff     <= monospace_in;
         scroll_enable_ff <= scroll_enable_in;
         wp_ff            <= wp_in;
         sp_ff            <= sp_in;
         full_ff          <= full_in;
         inflight_ff      <= inflight_in;
         count_ff         <= count_in;
      end
      glyph_ff   <= glyph_in;
      app_cnt_ff <= app_cnt_in;
      wrap_ff    <= wrap_in;
      ptr_ff     <= ptr_in;
      col_ff     <= col_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
      meta_ff    <= meta_in;
      zero_ff    <= zero_in;
      fifo0_ff   <= fifo0_in;
      fifo1_ff   <= fifo1_in;
   end

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overfilled");

   a_room_for_return: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> (count_ff != 2'd2 || pop))
      else $error("returning column has no buffer slot");

   a_ptr_in_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sclm_pkg::ST_EMIT) |-> ({1'b0, ptr_ff} < wrap_ff))
      else $error("read pointer beyond wrap length");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (emit_issue && col_last) |=> (state_ff == sclm_pkg::ST_IDLE))
      else $error("frame did not end after last column");

endmodule
